// File: rtl/wif_pkg.sv
// ----------------------------------------------------------------------------
// wif_pkg
// Shared types, constants and helpers of the whole identifier finder.
// ----------------------------------------------------------------------------
package wif_pkg;

    localparam int NAME_SLOTS = 16;
    localparam int NAME_IDX_W = 4;
    localparam int LEN_W      = 5;
    localparam int CMP_W      = LEN_W + 1;
    localparam int REG_W      = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NAME_LOW  = 2'd0,
        REG_NAME_HIGH = 2'd1,
        REG_NAME_LEN  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [NAME_SLOTS-1:0][7:0] name;
        logic [LEN_W-1:0]           len;
        logic                       ident_mode;
    } cfg_t;

    function automatic logic ident_char(input logic [7:0] c);
        ident_char = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h30 && c <= 8'h39) || c == CH_UNDERSCORE ||
                     c == CH_PERCENT;
    endfunction

endpackage

// File: rtl/whole_identifier_finder_core.sv
// the result for an end marker shows on m_tvalid in the cycle after its transfer
// throughput: one byte per cycle while s_tready is high, set by the single scan state update per transfer
// s_tready drops only while a result waits in the output register and m_tready is low
// reset: synchronous active-low aresetn clears scan state, name registers and m_tvalid
// ----------------------------------------------------------------------------
// whole_identifier_finder_core
// Scans a byte stream and reports whether the configured name is mentioned.
// ----------------------------------------------------------------------------
module whole_identifier_finder_core import wif_pkg::*; #(
    parameter int MAX_NAME_LEN = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // text_byte
    input  logic                 s_tlast,   // end_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata    // mentioned in bit 0, rest zero
);

    localparam int SLOTS = (MAX_NAME_LEN < NAME_SLOTS) ? MAX_NAME_LEN : NAME_SLOTS;

    cfg_t cfg;
    logic step;
    logic mentioned;
    logic out_valid_reg;
    logic out_bit_reg;

    wif_cfg_regs #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    wif_scan #(.SLOTS(SLOTS)) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .step        (step),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .mentioned   (mentioned)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && s_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && s_tlast) begin
            out_bit_reg <= mentioned;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_bit_reg};

endmodule

// File: rtl/wif_cfg_regs.sv
// ----------------------------------------------------------------------------
// wif_cfg_regs
// Name registers, effective length clamp and matching mode decode.
// ----------------------------------------------------------------------------
module wif_cfg_regs import wif_pkg::*; #(
    parameter int MAX_NAME_LEN = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    localparam logic [LEN_W-1:0] SLOT_LIM = LEN_W'(NAME_SLOTS);
    localparam logic [CMP_W-1:0] MAX_LIM  = CMP_W'(MAX_NAME_LEN);

    logic [REG_W-1:0] low_reg;
    logic [REG_W-1:0] high_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_a;
    logic [LEN_W-1:0] len_eff;
    logic             ident_all;
    logic [NAME_SLOTS-1:0][7:0] name_all;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_NAME_LOW:  low_reg  <= cfg_wdata;
                REG_NAME_HIGH: high_reg <= cfg_wdata;
                REG_NAME_LEN:  len_reg  <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign name_all = {high_reg, low_reg};

    always_comb begin
        len_a   = (len_reg > SLOT_LIM) ? SLOT_LIM : len_reg;
        len_eff = (CMP_W'(len_a) > MAX_LIM) ? MAX_LIM[LEN_W-1:0] : len_a;
    end

    always_comb begin
        ident_all = 1'b1;
        for (int i = 0; i < NAME_SLOTS; i++) begin
            if (LEN_W'(i) < len_eff && !ident_char(name_all[i])) begin
                ident_all = 1'b0;
            end
        end
    end

    assign cfg.name       = name_all;
    assign cfg.len        = len_eff;
    assign cfg.ident_mode = ident_all;

endmodule

// File: rtl/wif_scan.sv
// ----------------------------------------------------------------------------
// wif_scan
// Per-byte scan state: token compare, string literal skip, substring window.
// ----------------------------------------------------------------------------
module wif_scan import wif_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       mentioned
);

    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int TOK_W  = $clog2(SLOTS + 2);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SLOTS);
    localparam logic [TOK_W-1:0]  TOK_SAT  = TOK_W'(SLOTS + 1);

    logic              lit_reg,   lit_next;
    logic              skip_reg,  skip_next;
    logic [TOK_W-1:0]  tok_reg,   tok_next;
    logic              teq_reg,   teq_next;
    logic              found_reg, found_next;
    logic [FILL_W-1:0] fill_reg,  fill_next;
    logic [7:0]        win_reg  [SLOTS];
    logic [7:0]        win_next [SLOTS];

    logic [7:0]        push_byte;
    logic [7:0]        win_push [SLOTS];
    logic [FILL_W-1:0] fill_push;
    logic              match;
    logic              push_hit;
    logic [CMP_W-1:0]  tok_ext;
    logic              close_hit;
    logic              tok_miss;
    logic              do_push;
    logic              found_fin;
    logic [LEN_W-1:0]  idx;

    always_comb begin
        push_byte = end_of_text ? CH_BACKSLASH : text_byte;
        win_push[0] = push_byte;
        for (int k = 1; k < SLOTS; k++) begin
            win_push[k] = win_reg[k-1];
        end
        fill_push = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
        match = 1'b1;
        for (int k = 0; k < SLOTS; k++) begin
            idx = cfg.len - LEN_W'(k) - 1'b1;
            if (LEN_W'(k) < cfg.len && win_push[k] != cfg.name[idx[NAME_IDX_W-1:0]]) begin
                match = 1'b0;
            end
        end
        push_hit = (cfg.len != '0) && (CMP_W'(fill_push) >= CMP_W'(cfg.len)) && match;

        tok_ext   = CMP_W'(tok_reg);
        close_hit = (tok_reg != '0) && teq_reg && (tok_ext == CMP_W'(cfg.len));
        tok_miss  = (tok_ext >= CMP_W'(cfg.len)) ||
                    (text_byte != cfg.name[tok_ext[NAME_IDX_W-1:0]]);
    end

    always_comb begin
        lit_next   = lit_reg;
        skip_next  = skip_reg;
        tok_next   = tok_reg;
        teq_next   = teq_reg;
        found_next = found_reg;
        fill_next  = fill_reg;
        win_next   = win_reg;
        do_push    = 1'b0;
        found_fin  = found_reg | (cfg.ident_mode ? close_hit : (skip_reg & push_hit));

        if (end_of_text) begin
            lit_next   = 1'b0;
            skip_next  = 1'b0;
            tok_next   = '0;
            teq_next   = 1'b1;
            found_next = 1'b0;
            fill_next  = '0;
            for (int k = 0; k < SLOTS; k++) begin
                win_next[k] = '0;
            end
        end else if (cfg.ident_mode) begin
            if (lit_reg) begin
                if (skip_reg) begin
                    skip_next = 1'b0;
                end else if (text_byte == CH_BACKSLASH) begin
                    skip_next = 1'b1;
                end else if (text_byte == CH_QUOTE) begin
                    lit_next = 1'b0;
                end
            end else if (ident_char(text_byte)) begin
                if (tok_miss) begin
                    teq_next = 1'b0;
                end
                if (tok_reg != TOK_SAT) begin
                    tok_next = tok_reg + 1'b1;
                end
            end else begin
                found_next = found_reg | close_hit;
                tok_next   = '0;
                teq_next   = 1'b1;
                if (text_byte == CH_QUOTE) begin
                    lit_next  = 1'b1;
                    skip_next = 1'b0;
                end
            end
        end else begin
            if (skip_reg) begin
                skip_next = 1'b0;
                do_push   = 1'b1;
            end else if (text_byte == CH_BACKSLASH) begin
                skip_next = 1'b1;
            end else begin
                do_push = 1'b1;
            end
            if (do_push) begin
                win_next   = win_push;
                fill_next  = fill_push;
                found_next = found_reg | push_hit;
            end
        end
    end

    assign mentioned = (cfg.len != '0) && found_fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg   <= 1'b0;
            skip_reg  <= 1'b0;
            tok_reg   <= '0;
            teq_reg   <= 1'b1;
            found_reg <= 1'b0;
            fill_reg  <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                win_reg[k] <= '0;
            end
        end else if (step) begin
            lit_reg   <= lit_next;
            skip_reg  <= skip_next;
            tok_reg   <= tok_next;
            teq_reg   <= teq_next;
            found_reg <= found_next;
            fill_reg  <= fill_next;
            win_reg   <= win_next;
        end
    end

endmodule

// File: rtl/wif_checker.sv
// ----------------------------------------------------------------------------
// wif_checker
// Port-level checks of the whole identifier finder, bound to the top level.
// ----------------------------------------------------------------------------
module wif_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // results come only from an end marker transfer
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid && !m_tready)) |->
        $past(s_tvalid && s_tready && s_tlast))
        else $error("result without end marker transfer");

    // input side never stalls while the output register is free
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output");

    // only bit 0 of the result carries data
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] == 7'b0))
        else $error("result padding not zero");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind whole_identifier_finder_core wif_checker u_wif_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
